### sv/pkt_pkg.sv
// ----------------------------------------------------------------------------
// Polynomial kick tracker package
// Shared fixed-point constants, pipeline latencies, stage types and saturating
// add and subtract helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pkt_pkg;

    localparam int DATA_W = 64;
    localparam int TRIG_W = 32;
    localparam int FRAC_BITS = 40;
    localparam int TRIG_FRAC = 30;

    localparam logic signed [63:0] ONE_Q40 = 64'sh0000_0100_0000_0000;
    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

    // Multiplier: magnitude stage, partial product stage, combine stage.
    localparam int MUL_LAT = 3;

    // Divider: a 104-bit dividend, two quotient bits per stage.
    localparam int DIV_BITS = DATA_W + FRAC_BITS;
    localparam int DIV_STAGES = DIV_BITS / 2;
    localparam int DIV_LAT = DIV_STAGES + 2;

    // Square root: a 104-bit radicand, two root bits per stage.
    localparam int SQRT_BITS = DATA_W + FRAC_BITS;
    localparam int ROOT_W = SQRT_BITS / 2;
    localparam int SQRT_STAGES = SQRT_BITS / 4;
    localparam int SQRT_LAT = SQRT_STAGES;
    localparam int SREM_W = ROOT_W + 2;

    localparam int S_TDATA_W = 8 * DATA_W;
    localparam int M_TDATA_W = 6 * DATA_W;

    typedef enum logic [2:0] {
        CFG_STRENGTH,
        CFG_TILT_COS,
        CFG_TILT_SIN,
        CFG_OFFSET_X,
        CFG_OFFSET_Y,
        CFG_OFFSET_Z,
        CFG_POLY_ORDER,
        CFG_Y_PLANE
    } cfg_idx_t;

    typedef struct packed {
        logic [63:0]         rem;
        logic [63:0]         quo;
        logic [63:0]         dvs;
        logic [DIV_BITS-1:0] dvd;
        logic                ovf;
        logic                neg;
        logic                den_zero;
        logic                num_zero;
        logic                num_neg;
    } div_st_t;

    typedef struct packed {
        logic [SREM_W-1:0]    rem;
        logic [ROOT_W-1:0]    root;
        logic [SQRT_BITS-1:0] rad;
    } sqrt_st_t;

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
        begin
            r = a[63] ? SAT_MIN : SAT_MAX;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63])
        begin
            r = a[63] ? SAT_MIN : SAT_MAX;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        logic signed [63:0] n;
        n = -v;
        return v[63] ? 64'(n) : 64'(v);
    endfunction

endpackage

`default_nettype wire

### sv/pkt_dly.sv
// ----------------------------------------------------------------------------
// Polynomial kick tracker delay line
// Shift register that keeps side values aligned with the arithmetic stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pkt_dly #(
    parameter int W = 64,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] sh_reg [0:N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                sh_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            sh_reg[0] <= din;
            for (int i = 1; i < N; i++)
            begin
                sh_reg[i] <= sh_reg[i-1];
            end
        end
    end

    assign dout = sh_reg[N-1];

endmodule

`default_nettype wire

### sv/pkt_mul.sv
// ----------------------------------------------------------------------------
// Polynomial kick tracker multiplier
// Three-stage signed fixed-point multiply with round half away from zero,
// right shift by SH and saturation to 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pkt_mul #(
    parameter int SH = 40
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p
);

    logic        neg_a_reg;
    logic [63:0] ma_reg;
    logic [63:0] mb_reg;
    logic        neg_b_reg;
    logic [63:0] p00_reg;
    logic [63:0] p01_reg;
    logic [63:0] p10_reg;
    logic [63:0] p11_reg;
    logic signed [63:0] p_reg;

    logic [127:0] acc;
    logic [127:0] shf;
    logic [63:0]  lim;
    logic [63:0]  res;

    // The rounding constant cannot carry out of 128 bits: magnitudes are at most 2^63.
    always_comb
    begin
        acc = {64'd0, p00_reg} + ({64'd0, p01_reg} << 32) + ({64'd0, p10_reg} << 32)
            + {p11_reg, 64'd0} + (128'd1 << (SH - 1));
        shf = acc >> SH;
        lim = neg_b_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        res = (|shf[127:64] || shf[63:0] > lim) ? lim : shf[63:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= a[63] ^ b[63];
            ma_reg    <= pkt_pkg::mag(a);
            mb_reg    <= pkt_pkg::mag(b);
            neg_b_reg <= neg_a_reg;
            p00_reg   <= ma_reg[31:0] * mb_reg[31:0];
            p01_reg   <= ma_reg[31:0] * mb_reg[63:32];
            p10_reg   <= ma_reg[63:32] * mb_reg[31:0];
            p11_reg   <= ma_reg[63:32] * mb_reg[63:32];
            p_reg     <= neg_b_reg ? -$signed(res) : $signed(res);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

### sv/pkt_div.sv
// ----------------------------------------------------------------------------
// Polynomial kick tracker divider
// Pipelined restoring division of a Q23.40 value by a Q23.40 value, two
// quotient bits per stage, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module pkt_div (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic signed [63:0] q
);

    localparam int S = pkt_pkg::DIV_STAGES;
    localparam int DB = pkt_pkg::DIV_BITS;

    pkt_pkg::div_st_t st_reg [0:S];
    logic signed [63:0] q_reg;

    function automatic logic [64:0] dstep(input logic [63:0] r, input logic bi,
                                          input logic [63:0] d);
        logic [64:0] t;
        logic [64:0] df;
        t = {r, bi};
        df = t - {1'b0, d};
        if (t >= {1'b0, d})
        begin
            return {1'b1, df[63:0]};
        end
        return {1'b0, t[63:0]};
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].rem      <= '0;
            st_reg[0].quo      <= '0;
            st_reg[0].dvs      <= pkt_pkg::mag(den);
            st_reg[0].dvd      <= {pkt_pkg::mag(num), {pkt_pkg::FRAC_BITS{1'b0}}};
            st_reg[0].ovf      <= 1'b0;
            st_reg[0].neg      <= num[63] ^ den[63];
            st_reg[0].den_zero <= (den == '0);
            st_reg[0].num_zero <= (num == '0);
            st_reg[0].num_neg  <= num[63];
        end
    end

    for (genvar k = 1; k <= S; k++)
    begin : g_stage
        pkt_pkg::div_st_t nx;
        logic [64:0] s1;
        logic [64:0] s2;

        always_comb
        begin
            nx = st_reg[k-1];
            s1 = dstep(st_reg[k-1].rem, st_reg[k-1].dvd[DB-1], st_reg[k-1].dvs);
            s2 = dstep(s1[63:0], st_reg[k-1].dvd[DB-2], st_reg[k-1].dvs);
            nx.rem = s2[63:0];
            nx.quo = {st_reg[k-1].quo[61:0], s1[64], s2[64]};
            nx.ovf = st_reg[k-1].ovf | st_reg[k-1].quo[63] | st_reg[k-1].quo[62];
            nx.dvd = st_reg[k-1].dvd << 2;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= nx;
            end
        end
    end

    logic [63:0] lim;
    logic [63:0] qm;

    always_comb
    begin
        lim = st_reg[S].neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        qm = (st_reg[S].ovf || st_reg[S].quo > lim) ? lim : st_reg[S].quo;
    end

    // A zero denominator gives the extreme with the sign of the numerator, or zero for a zero numerator.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (st_reg[S].den_zero)
            begin
                if (st_reg[S].num_zero)
                begin
                    q_reg <= '0;
                end
                else
                begin
                    q_reg <= st_reg[S].num_neg ? pkt_pkg::SAT_MIN : pkt_pkg::SAT_MAX;
                end
            end
            else
            begin
                q_reg <= st_reg[S].neg ? -$signed(qm) : $signed(qm);
            end
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

### sv/pkt_sqrt.sv
// ----------------------------------------------------------------------------
// Polynomial kick tracker square root
// Pipelined digit-by-digit floor square root of a non-negative Q23.40 value,
// two root bits per stage, result in Q23.40.
// ----------------------------------------------------------------------------
`default_nettype none

module pkt_sqrt (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] s,
    output logic signed [63:0] r
);

    localparam int S = pkt_pkg::SQRT_STAGES;
    localparam int RB = pkt_pkg::SQRT_BITS;
    localparam int RW = pkt_pkg::ROOT_W;
    localparam int EW = pkt_pkg::SREM_W;

    pkt_pkg::sqrt_st_t st_reg [1:S];
    pkt_pkg::sqrt_st_t init;

    function automatic logic [EW+RW-1:0] sstep(input logic [EW-1:0] rem,
                                               input logic [1:0] bits,
                                               input logic [RW-1:0] root);
        logic [EW+1:0] t;
        logic [EW+1:0] tr;
        logic [EW+1:0] df;
        t = {rem, bits};
        tr = {2'b00, root, 2'b01};
        df = t - tr;
        if (t >= tr)
        begin
            return {df[EW-1:0], root[RW-2:0], 1'b1};
        end
        return {t[EW-1:0], root[RW-2:0], 1'b0};
    endfunction

    always_comb
    begin
        init.rem = '0;
        init.root = '0;
        init.rad = {s, {pkt_pkg::FRAC_BITS{1'b0}}};
    end

    for (genvar k = 1; k <= S; k++)
    begin : g_stage
        pkt_pkg::sqrt_st_t cur;
        pkt_pkg::sqrt_st_t nx;
        logic [EW+RW-1:0] a1;
        logic [EW+RW-1:0] a2;

        if (k == 1)
        begin : g_first
            assign cur = init;
        end
        else
        begin : g_next
            assign cur = st_reg[k-1];
        end

        always_comb
        begin
            a1 = sstep(cur.rem, cur.rad[RB-1:RB-2], cur.root);
            a2 = sstep(a1[EW+RW-1:RW], cur.rad[RB-3:RB-4], a1[RW-1:0]);
            nx.rem = a2[EW+RW-1:RW];
            nx.root = a2[RW-1:0];
            nx.rad = cur.rad << 4;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= nx;
            end
        end
    end

    assign r = $signed({{(64 - RW){1'b0}}, st_reg[S].root});

endmodule

`default_nettype wire

### sv/polynomial_kick_tracker.sv
// ----------------------------------------------------------------------------
// Polynomial kick tracker
// Applies a tilted, offset thin polynomial kick to one particle per transfer
// and flags particles beyond the coordinate and slope limits as lost.
// ----------------------------------------------------------------------------
// Depth: the 104-bit divider for strength/(1+delta) sets the pipeline depth at
//   MAX_ORDER 15, and from MAX_ORDER 16 up the power chain, one multiplier per
//   order, sets it, plus the 26-stage root and rotation.
// Throughput: one particle per cycle; a stall at the output freezes all stages.
// Reset clears the valid bits; configuration registers and delay lines reset to zero, with the tilt cosine at 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_kick_tracker #(
    parameter logic [63:0] COORD_LIM = 64'd10995116277760,
    parameter logic [63:0] SLOPE_LIM = 64'd1099511627776,
    parameter int          MAX_ORDER = 15
) (
    input  logic         clk,
    input  logic         rst_n,
    // x_pos, x_slope, y_pos, y_slope, path_s, delta, lost_s, ref_momentum
    input  logic [511:0] s_tdata,
    input  logic         s_tlast,
    input  logic         s_tvalid,
    output logic         s_tready,
    // x_out, xp_out, y_out, yp_out, s_out, delta_out
    output logic [383:0] m_tdata,
    // lost
    output logic         m_tuser,
    output logic         m_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam logic signed [63:0] ONE = pkt_pkg::ONE_Q40;
    localparam int ML = pkt_pkg::MUL_LAT;
    localparam int SL = pkt_pkg::SQRT_LAT;
    localparam int DL = pkt_pkg::DIV_LAT;
    localparam int PL = MAX_ORDER * ML;
    localparam int T_K = (((1 + DL) > (8 + PL)) ? (1 + DL) : (8 + PL)) + 1;
    localparam int T_L = T_K + 8;
    localparam int T_F = T_L + 9 + SL;
    localparam int OW = ($clog2(MAX_ORDER + 1) > 4) ? $clog2(MAX_ORDER + 1) : 4;

    // Configuration registers.
    logic signed [63:0] strength_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic signed [63:0] dx_reg;
    logic signed [63:0] dy_reg;
    logic signed [63:0] dz_reg;
    logic [3:0]         order_reg;
    logic               yplane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= '0;
            cos_reg      <= 32'sh4000_0000;
            sin_reg      <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            dz_reg       <= '0;
            order_reg    <= '0;
            yplane_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (pkt_pkg::cfg_idx_t'(cfg_index))
                pkt_pkg::CFG_STRENGTH:   strength_reg <= cfg_data;
                pkt_pkg::CFG_TILT_COS:   cos_reg <= cfg_data[31:0];
                pkt_pkg::CFG_TILT_SIN:   sin_reg <= cfg_data[31:0];
                pkt_pkg::CFG_OFFSET_X:   dx_reg <= cfg_data;
                pkt_pkg::CFG_OFFSET_Y:   dy_reg <= cfg_data;
                pkt_pkg::CFG_OFFSET_Z:   dz_reg <= cfg_data;
                pkt_pkg::CFG_POLY_ORDER: order_reg <= cfg_data[3:0];
                pkt_pkg::CFG_Y_PLANE:    yplane_reg <= cfg_data[0];
                default:                 yplane_reg <= yplane_reg;
            endcase
        end
    end

    logic signed [63:0] cos64;
    logic signed [63:0] sin64;
    logic [OW-1:0]      n_eff;

    assign cos64 = {{32{cos_reg[31]}}, cos_reg};
    assign sin64 = {{32{sin_reg[31]}}, sin_reg};
    assign n_eff = (OW'(order_reg) > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : OW'(order_reg);

    // Whole-pipeline advance: every stage moves unless the output holds a result that is not taken.
    logic adv;
    logic out_valid_reg;

    assign adv = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // Input stage.
    logic               in_valid_reg;
    logic signed [63:0] xi_reg, xpi_reg, yi_reg, ypi_reg;
    logic signed [63:0] si_reg, di_reg, ls_reg, pref_reg;
    logic               last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xi_reg   <= s_tdata[63:0];
            xpi_reg  <= s_tdata[127:64];
            yi_reg   <= s_tdata[191:128];
            ypi_reg  <= s_tdata[255:192];
            si_reg   <= s_tdata[319:256];
            di_reg   <= s_tdata[383:320];
            ls_reg   <= s_tdata[447:384];
            pref_reg <= s_tdata[511:448];
            last_reg <= s_tlast;
        end
    end

    // Offsets, momentum denominator and input rotation.
    logic signed [63:0] onepd_reg, dxo_reg, dyo_reg, pref1_reg;
    logic signed [63:0] dxo3, dyo3;
    logic signed [63:0] m_dzxp, m_dzyp, m_xp2, m_yp2, m_cxp, m_syp, m_cyp, m_sxp, m_dl;
    logic signed [63:0] ox_reg, oy_reg, rxp_reg, ryp_reg, ssa_reg, yp2d_reg;
    logic signed [63:0] ss_reg, xd_reg, yd_reg;
    logic signed [63:0] m_cox, m_soy, m_coy, m_sox;
    logic signed [63:0] rx_reg, ry_reg, rxp8, ryp8;
    logic               lost_reg;

    pkt_mul #(.SH(40)) u_dzxp (.clk(clk), .en(adv), .a(dz_reg), .b(xpi_reg), .p(m_dzxp));
    pkt_mul #(.SH(40)) u_dzyp (.clk(clk), .en(adv), .a(dz_reg), .b(ypi_reg), .p(m_dzyp));
    pkt_mul #(.SH(40)) u_xp2  (.clk(clk), .en(adv), .a(xpi_reg), .b(xpi_reg), .p(m_xp2));
    pkt_mul #(.SH(40)) u_yp2  (.clk(clk), .en(adv), .a(ypi_reg), .b(ypi_reg), .p(m_yp2));
    pkt_mul #(.SH(30)) u_cxp  (.clk(clk), .en(adv), .a(cos64), .b(xpi_reg), .p(m_cxp));
    pkt_mul #(.SH(30)) u_syp  (.clk(clk), .en(adv), .a(sin64), .b(ypi_reg), .p(m_syp));
    pkt_mul #(.SH(30)) u_cyp  (.clk(clk), .en(adv), .a(cos64), .b(ypi_reg), .p(m_cyp));
    pkt_mul #(.SH(30)) u_sxp  (.clk(clk), .en(adv), .a(sin64), .b(xpi_reg), .p(m_sxp));
    pkt_mul #(.SH(40)) u_dl   (.clk(clk), .en(adv), .a(pref1_reg), .b(onepd_reg), .p(m_dl));

    pkt_dly #(.W(128), .N(2)) u_dxo (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .din({dyo_reg, dxo_reg}), .dout({dyo3, dxo3})
    );

    pkt_mul #(.SH(30)) u_cox (.clk(clk), .en(adv), .a(cos64), .b(ox_reg), .p(m_cox));
    pkt_mul #(.SH(30)) u_soy (.clk(clk), .en(adv), .a(sin64), .b(oy_reg), .p(m_soy));
    pkt_mul #(.SH(30)) u_coy (.clk(clk), .en(adv), .a(cos64), .b(oy_reg), .p(m_coy));
    pkt_mul #(.SH(30)) u_sox (.clk(clk), .en(adv), .a(sin64), .b(ox_reg), .p(m_sox));

    pkt_dly #(.W(128), .N(4)) u_rp8 (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .din({ryp_reg, rxp_reg}), .dout({ryp8, rxp8})
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            onepd_reg <= pkt_pkg::sadd(ONE, di_reg);
            dxo_reg   <= pkt_pkg::ssub(xi_reg, dx_reg);
            dyo_reg   <= pkt_pkg::ssub(yi_reg, dy_reg);
            pref1_reg <= pref_reg;
            ox_reg    <= pkt_pkg::sadd(dxo3, m_dzxp);
            oy_reg    <= pkt_pkg::sadd(dyo3, m_dzyp);
            rxp_reg   <= pkt_pkg::sadd(m_cxp, m_syp);
            ryp_reg   <= pkt_pkg::ssub(m_cyp, m_sxp);
            ssa_reg   <= pkt_pkg::sadd(ONE, m_xp2);
            yp2d_reg  <= m_yp2;
            ss_reg    <= pkt_pkg::sadd(ssa_reg, yp2d_reg);
            xd_reg    <= pkt_pkg::sadd(ox_reg, dx_reg);
            yd_reg    <= pkt_pkg::sadd(oy_reg, dy_reg);
            rx_reg    <= pkt_pkg::sadd(m_cox, m_soy);
            ry_reg    <= pkt_pkg::ssub(m_coy, m_sox);
            lost_reg  <= (pkt_pkg::mag(rx_reg) > COORD_LIM) || (pkt_pkg::mag(ry_reg) > COORD_LIM)
                      || (pkt_pkg::mag(rxp8) > SLOPE_LIM) || (pkt_pkg::mag(ryp8) > SLOPE_LIM);
        end
    end

    // Path length through the element entry.
    logic signed [63:0] root1, m_dzr1, si_d, sh_reg;

    pkt_sqrt u_root1 (.clk(clk), .en(adv), .s(ss_reg), .r(root1));
    pkt_mul #(.SH(40)) u_dzr1 (.clk(clk), .en(adv), .a(dz_reg), .b(root1), .p(m_dzr1));
    pkt_dly #(.W(64), .N(8 + SL)) u_si (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(si_reg), .dout(si_d)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sh_reg <= pkt_pkg::sadd(si_d, m_dzr1);
        end
    end

    // Kick coefficient and power chain; an inactive stage multiplies by one.
    logic signed [63:0] kcoef, kc_k, pw_k, m_kick;
    logic signed [63:0] pw_r [0:MAX_ORDER];
    logic signed [63:0] pw_v [0:MAX_ORDER-1];

    pkt_div u_div (.clk(clk), .en(adv), .num(strength_reg), .den(onepd_reg), .q(kcoef));

    assign pw_r[0] = ONE;
    assign pw_v[0] = yplane_reg ? ry_reg : rx_reg;

    for (genvar k = 0; k < MAX_ORDER; k++)
    begin : g_pow
        logic signed [63:0] bop;

        assign bop = (OW'(k) < n_eff) ? pw_v[k] : ONE;

        pkt_mul #(.SH(40)) u_pw (.clk(clk), .en(adv), .a(pw_r[k]), .b(bop), .p(pw_r[k+1]));

        if (k < MAX_ORDER - 1)
        begin : g_v
            pkt_dly #(.W(64), .N(ML)) u_v (
                .clk(clk), .rst_n(rst_n), .en(adv), .din(pw_v[k]), .dout(pw_v[k+1])
            );
        end
    end

    pkt_dly #(.W(64), .N(T_K - 1 - DL)) u_kc (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(kcoef), .dout(kc_k)
    );
    pkt_dly #(.W(64), .N(T_K - 8 - PL)) u_pw_al (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(pw_r[MAX_ORDER]), .dout(pw_k)
    );
    pkt_mul #(.SH(40)) u_kick (.clk(clk), .en(adv), .a(kc_k), .b(pw_k), .p(m_kick));

    // Kick, rotate back and remove the offsets.
    logic signed [63:0] rxp_k, ryp_k, rxpk_reg, rypk_reg;
    logic signed [63:0] m_crx, m_sry, m_srx, m_cry, lxp_reg, lyp_reg;
    logic signed [63:0] m_lxdz, m_lydz, m_lx2, m_ly2, xd_l, yd_l;
    logic signed [63:0] xo_reg, yo_reg, ss2a_reg, ly2d_reg, ss2_reg;
    logic signed [63:0] root2, m_dzr2, sh_d, so_reg;

    pkt_dly #(.W(128), .N(T_K - 5)) u_rpk (
        .clk(clk), .rst_n(rst_n), .en(adv), .din({ryp8, rxp8}), .dout({ryp_k, rxp_k})
    );

    pkt_mul #(.SH(30)) u_crx (.clk(clk), .en(adv), .a(cos64), .b(rxpk_reg), .p(m_crx));
    pkt_mul #(.SH(30)) u_sry (.clk(clk), .en(adv), .a(sin64), .b(rypk_reg), .p(m_sry));
    pkt_mul #(.SH(30)) u_srx (.clk(clk), .en(adv), .a(sin64), .b(rxpk_reg), .p(m_srx));
    pkt_mul #(.SH(30)) u_cry (.clk(clk), .en(adv), .a(cos64), .b(rypk_reg), .p(m_cry));

    pkt_mul #(.SH(40)) u_lxdz (.clk(clk), .en(adv), .a(lxp_reg), .b(dz_reg), .p(m_lxdz));
    pkt_mul #(.SH(40)) u_lydz (.clk(clk), .en(adv), .a(lyp_reg), .b(dz_reg), .p(m_lydz));
    pkt_mul #(.SH(40)) u_lx2  (.clk(clk), .en(adv), .a(lxp_reg), .b(lxp_reg), .p(m_lx2));
    pkt_mul #(.SH(40)) u_ly2  (.clk(clk), .en(adv), .a(lyp_reg), .b(lyp_reg), .p(m_ly2));

    pkt_dly #(.W(128), .N(T_L - 2)) u_xd (
        .clk(clk), .rst_n(rst_n), .en(adv), .din({yd_reg, xd_reg}), .dout({yd_l, xd_l})
    );

    pkt_sqrt u_root2 (.clk(clk), .en(adv), .s(ss2_reg), .r(root2));
    pkt_mul #(.SH(40)) u_dzr2 (.clk(clk), .en(adv), .a(dz_reg), .b(root2), .p(m_dzr2));
    pkt_dly #(.W(64), .N(T_L - 1)) u_sh (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(sh_reg), .dout(sh_d)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rxpk_reg <= yplane_reg ? rxp_k : pkt_pkg::sadd(rxp_k, m_kick);
            rypk_reg <= yplane_reg ? pkt_pkg::sadd(ryp_k, m_kick) : ryp_k;
            lxp_reg  <= pkt_pkg::ssub(m_crx, m_sry);
            lyp_reg  <= pkt_pkg::sadd(m_srx, m_cry);
            xo_reg   <= pkt_pkg::ssub(xd_l, m_lxdz);
            yo_reg   <= pkt_pkg::ssub(yd_l, m_lydz);
            ss2a_reg <= pkt_pkg::sadd(ONE, m_lx2);
            ly2d_reg <= m_ly2;
            ss2_reg  <= pkt_pkg::sadd(ss2a_reg, ly2d_reg);
            so_reg   <= pkt_pkg::ssub(sh_d, m_dzr2);
        end
    end

    // Alignment of every result to the final stage.
    logic signed [63:0] xo_f, yo_f, lxp_f, lyp_f;
    logic signed [63:0] ox_f, oy_f, dl_f, xpi_f, ypi_f, ls_f, di_f;
    logic               last_f, lost_f, v_f;

    pkt_dly #(.W(128), .N(5 + SL)) u_xo_f (
        .clk(clk), .rst_n(rst_n), .en(adv), .din({yo_reg, xo_reg}), .dout({yo_f, xo_f})
    );
    pkt_dly #(.W(128), .N(9 + SL)) u_lp_f (
        .clk(clk), .rst_n(rst_n), .en(adv), .din({lyp_reg, lxp_reg}), .dout({lyp_f, lxp_f})
    );
    pkt_dly #(.W(192), .N(T_F - 4)) u_o_f (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .din({m_dl, oy_reg, ox_reg}), .dout({dl_f, oy_f, ox_f})
    );
    pkt_dly #(.W(257), .N(T_F)) u_in_f (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .din({last_reg, di_reg, ls_reg, ypi_reg, xpi_reg}),
        .dout({last_f, di_f, ls_f, ypi_f, xpi_f})
    );
    pkt_dly #(.W(1), .N(T_F - 9)) u_lost_f (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(lost_reg), .dout(lost_f)
    );
    pkt_dly #(.W(1), .N(T_F)) u_v_f (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(in_valid_reg), .dout(v_f)
    );

    // Output register.
    logic [383:0] tdata_reg;
    logic         tuser_reg;
    logic         tlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v_f;
        end
    end

    // A lost particle keeps its offset positions and input slopes.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (lost_f)
            begin
                tdata_reg <= {dl_f, ls_f, ypi_f, oy_f, xpi_f, ox_f};
            end
            else
            begin
                tdata_reg <= {di_f, so_reg, lyp_f, yo_f, lxp_f, xo_f};
            end
            tuser_reg <= lost_f;
            tlast_reg <= last_f;
        end
    end

    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;
    assign m_tvalid = out_valid_reg;

    a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted transfer did not enter the input stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_f))
        else $error("final stage valid moved during a stall");

    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v_f) |=> m_tvalid)
        else $error("finished particle was not presented at the output");

endmodule

`default_nettype wire
